// ===== hw/rtl/edpa_pkg.sv =====
// shared constants, codes and types of the dirichlet posterior accumulator
package edpa_pkg;

    // table geometry, fixed by the index field widths
    localparam int NUM_PLACES   = 256;
    localparam int NUM_OUTCOMES = 8;
    localparam int NUM_GROUPS   = 8;
    localparam int X_W          = 8;
    localparam int Y_W          = 3;
    localparam int R_W          = 3;
    localparam int CELL_W       = X_W + Y_W + R_W;
    localparam int TOT_W        = X_W + R_W;
    localparam int PRI_W        = Y_W + R_W;
    localparam int CELLS        = NUM_PLACES * NUM_OUTCOMES * NUM_GROUPS;
    localparam int TOTS         = NUM_PLACES * NUM_GROUPS;
    localparam int PRIS         = NUM_OUTCOMES * NUM_GROUPS;

    // datapath widths
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 48;
    localparam int SUM_W     = 56;
    localparam int CSUM_W    = 40;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // fixed point constants
    localparam logic [DIV_W-1:0] ONE_Q16 = 64'd65536;
    localparam logic [CNT_W-1:0] CNT_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0] BUF_MAX = 48'hFFFF_FFFF_FFFF;

    // item kinds
    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_PRIOR = 3'd1;
    localparam logic [2:0] KIND_EST   = 3'd2;
    localparam logic [2:0] KIND_OBS   = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    // divider request and status
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/edpa_mul.sv =====
// registered 32 by 32 unsigned multiplier shared by the sequencer
module edpa_mul (
    input  logic                          clk,
    input  logic [edpa_pkg::VAL_W-1:0]    a,
    input  logic [edpa_pkg::VAL_W-1:0]    b,
    output logic [edpa_pkg::PROD_W-1:0]   prod
);
    import edpa_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // one product per cycle, the product is registered
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/edpa_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module edpa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  edpa_pkg::div_req_t          req,
    output edpa_pkg::div_stat_t         stat,
    output logic [edpa_pkg::DIV_W-1:0]  quotient
);
    import edpa_pkg::*;

    logic [DIV_W:0]       rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 ge;

    // trial subtract of the shifted partial remainder
    assign shifted = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = !diff[DIV_W];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : shifted;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hw/rtl/em_dirichlet_posterior_accumulator.sv =====
// dirichlet posterior accumulator: sequencer, tables and shared arithmetic
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: place, outcome, group, value, weight; tuser kind; tlast
// m_*      out  m_tvalid/m_tready  tdata: result_value; tuser: status
// apb      in   psel/penable       reg 0 bayes_mode at 0x0, reg 1 raw count mode at 0x4
//
// a prior load reads then writes the prior table, an estimate load writes one entry, and an
// observation word reads, multiplies and adds; a final word then walks every group, through
// the 64-step serial divider in bayes mode; a read divides but not in raw count mode
// reset and a clear word start a sweep over all 16384 entries of the count memory,
// during which s_tready stays low; configuration writes are taken at any time
// a finished result waits in the output register while the next word is taken
module em_dirichlet_posterior_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // place[7:0], outcome[10:8], group[13:11], value[45:14], weight[77:46], zero pad
    input  logic [79:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_value[47:0]
    output logic [47:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);
    import edpa_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PRI_RD, S_PRI_WR, S_EST_WR,
        S_OBS_RD, S_OBS_MUL, S_OBS_ADD, S_ROW_CHK, S_ROW_DIV, S_ROW_DIVW,
        S_ROW_MUL_LO, S_ROW_MUL_HI, S_ROW_ADD, S_RD_RD, S_RD_CALC, S_RD_DIVW, S_EMIT
    } state_t;

    localparam logic [DIV_W-1:0] DEN_OFS  = DIV_W'(NUM_OUTCOMES) * ONE_Q16;
    localparam logic [DIV_W-1:0] CNT_MAX_W = {{(DIV_W-CNT_W){1'b0}}, CNT_MAX};

    // registers
    state_t              state_reg, state_next;
    logic                bayes_reg, bayes_next;
    logic                raw_reg, raw_next;
    logic [2:0]          kind_reg, kind_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [Y_W-1:0]      y_reg, y_next;
    logic [R_W-1:0]      r_reg, r_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [VAL_W-1:0]    wt_reg, wt_next;
    logic                last_reg, last_next;
    logic [R_W-1:0]      k_reg, k_next;
    logic [CELL_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    buf_reg [NUM_GROUPS];
    logic [CNT_W-1:0]    buf_next [NUM_GROUPS];
    logic [SUM_W-1:0]    row_sum_reg, row_sum_next;
    logic [CSUM_W-1:0]   csum_reg [NUM_GROUPS];
    logic [CSUM_W-1:0]   csum_next [NUM_GROUPS];
    logic [PRIS-1:0]     pri_vld_reg, pri_vld_next;
    logic [CNT_W-1:0]    share_reg, share_next;
    logic [PROD_W-1:0]   lo_reg, lo_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    res_reg, res_next;
    logic [1:0]          res_st_reg, res_st_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    out_data_reg, out_data_next;
    logic [1:0]          out_user_reg, out_user_next;

    // memories and their registered read data
    logic [VAL_W-1:0]    est_mem [CELLS];
    logic [CNT_W-1:0]    cnt_mem [CELLS];
    logic [CNT_W-1:0]    tot_mem [TOTS];
    logic [VAL_W-1:0]    pri_mem [PRIS];
    logic [VAL_W-1:0]    est_rd_reg;
    logic [CNT_W-1:0]    cnt_rd_reg;
    logic [CNT_W-1:0]    tot_rd_reg;
    logic [VAL_W-1:0]    pri_rd_reg;

    // datapath signals
    logic                s_accept;
    logic                out_free;
    logic                row_phase;
    logic                clearing;
    logic [R_W-1:0]      rsel;
    logic [CELL_W-1:0]   cell_addr;
    logic [CELL_W-1:0]   cnt_addr;
    logic [TOT_W-1:0]    tot_addr;
    logic [PRI_W-1:0]    pri_addr;
    logic                est_we;
    logic                pri_we;
    logic                acc_we;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [CNT_W-1:0]    tot_wdata;
    logic [VAL_W-1:0]    mul_a;
    logic [VAL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod;
    div_req_t            div_req;
    div_stat_t           div_stat;
    logic [DIV_W-1:0]    quotient;
    logic [CNT_W-1:0]    buf_rd;
    logic [CNT_W-1:0]    term;
    logic [CNT_W:0]      bsum;
    logic [CNT_W-1:0]    nb;
    logic [CNT_W:0]      radd;
    logic [CNT_W-1:0]    add;
    logic [CNT_W:0]      csum_cnt;
    logic [CNT_W:0]      csum_tot;
    logic signed [DIV_W-1:0] num;
    logic signed [DIV_W-1:0] den;
    logic [DIV_W-1:0]    un;
    logic [DIV_W-1:0]    ud;
    logic [DIV_W-1:0]    qq;
    logic                cfg_wr;

    // shared arithmetic units
    edpa_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    edpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // handshakes and addressing
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign row_phase = (state_reg == S_ROW_DIV) || (state_reg == S_ROW_DIVW)
                    || (state_reg == S_ROW_MUL_LO) || (state_reg == S_ROW_MUL_HI)
                    || (state_reg == S_ROW_ADD);
    assign clearing  = (state_reg == S_CLEAR);
    assign rsel      = row_phase ? k_reg : r_reg;
    assign cell_addr = {x_reg, y_reg, r_reg};
    assign cnt_addr  = {x_reg, y_reg, rsel};
    assign tot_addr  = {x_reg, rsel};
    assign pri_addr  = {y_reg, r_reg};
    assign est_we    = (state_reg == S_EST_WR);
    assign pri_we    = (state_reg == S_PRI_WR);
    assign acc_we    = clearing || (state_reg == S_ROW_ADD);
    assign buf_rd    = buf_reg[rsel];

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = wt_reg;
        case (state_reg)
            S_OBS_MUL:
            begin
                mul_a = est_rd_reg;
                mul_b = val_reg;
            end
            S_ROW_MUL_LO: mul_a = share_reg[VAL_W-1:0];
            S_ROW_MUL_HI: mul_a = VAL_W'(share_reg[CNT_W-1:VAL_W]);
            default:      mul_a = '0;
        endcase
    end

    // element term into the row buffer, saturating
    assign term = bayes_reg ? prod[PROD_W-1:16] : CNT_W'(val_reg);
    assign bsum = {1'b0, buf_rd} + {1'b0, term};
    assign nb   = bsum[CNT_W] ? BUF_MAX : bsum[CNT_W-1:0];

    // share times weight from the two partial products
    assign radd = {1'b0, prod[31:0], 16'b0} + {1'b0, lo_reg[PROD_W-1:16]};
    assign add  = ((|prod[PROD_W-1:32]) || radd[CNT_W]) ? BUF_MAX : radd[CNT_W-1:0];

    // count and total update, saturating at the signed maximum
    assign csum_cnt  = {1'b0, cnt_rd_reg} + {1'b0, add};
    assign csum_tot  = {1'b0, tot_rd_reg} + {1'b0, add};
    assign cnt_wdata = clearing ? '0
                     : (csum_cnt > {1'b0, CNT_MAX}) ? CNT_MAX : csum_cnt[CNT_W-1:0];
    assign tot_wdata = clearing ? '0
                     : (csum_tot > {1'b0, CNT_MAX}) ? CNT_MAX : csum_tot[CNT_W-1:0];

    // posterior mode numerator and denominator
    assign num = $signed(DIV_W'(pri_rd_reg)) - $signed(ONE_Q16) + $signed(DIV_W'(cnt_rd_reg));
    assign den = $signed(DIV_W'(csum_reg[r_reg])) - $signed(DEN_OFS)
               + $signed(DIV_W'(tot_rd_reg));
    assign un  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
    assign ud  = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
    assign qq  = (quotient > CNT_MAX_W + 1'b1) ? CNT_MAX_W + 1'b1 : quotient;

    // divider requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {buf_rd, 16'b0};
        div_req.divisor  = DIV_W'(row_sum_reg);
        if (state_reg == S_ROW_DIV)
        begin
            div_req.start = bayes_reg;
        end
        else if (state_reg == S_RD_CALC)
        begin
            div_req.start    = !raw_reg && (den != 0);
            div_req.dividend = {un[DIV_W-17:0], 16'b0};
            div_req.divisor  = ud;
        end
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            1'b0:    prdata = {31'b0, bayes_reg};
            default: prdata = {31'b0, raw_reg};
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        bayes_next     = bayes_reg;
        raw_next       = raw_reg;
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        r_next         = r_reg;
        val_next       = val_reg;
        wt_next        = wt_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        buf_next       = buf_reg;
        row_sum_next   = row_sum_reg;
        csum_next      = csum_reg;
        pri_vld_next   = pri_vld_reg;
        share_next     = share_reg;
        lo_next        = lo_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (cfg_wr)
        begin
            if (paddr[2])
            begin
                raw_next = pwdata[0];
            end
            else
            begin
                bayes_next = pwdata[0];
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CELL_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_accept)
                begin
                    kind_next = s_tuser;
                    x_next    = s_tdata[7:0];
                    y_next    = s_tdata[10:8];
                    r_next    = s_tdata[13:11];
                    val_next  = s_tdata[45:14];
                    wt_next   = s_tdata[77:46];
                    last_next = s_tlast;
                    case (s_tuser)
                        KIND_CLEAR:
                        begin
                            for (int i = 0; i < NUM_GROUPS; i++)
                            begin
                                buf_next[i] = '0;
                            end
                            row_sum_next = '0;
                            clr_next     = '0;
                            state_next   = S_CLEAR;
                        end
                        KIND_PRIOR: state_next = S_PRI_RD;
                        KIND_EST:   state_next = S_EST_WR;
                        KIND_OBS:   state_next = S_OBS_RD;
                        KIND_READ:  state_next = S_RD_RD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_PRI_RD: state_next = S_PRI_WR;
            S_PRI_WR:
            begin
                // an entry never loaded counts as zero in the column sum
                csum_next[r_reg] = csum_reg[r_reg]
                                 - (pri_vld_reg[pri_addr] ? CSUM_W'(pri_rd_reg) : CSUM_W'(0))
                                 + CSUM_W'(val_reg);
                pri_vld_next[pri_addr] = 1'b1;
                state_next       = S_IDLE;
            end
            S_EST_WR: state_next = S_IDLE;
            S_OBS_RD: state_next = S_OBS_MUL;
            S_OBS_MUL: state_next = S_OBS_ADD;
            S_OBS_ADD:
            begin
                buf_next[r_reg] = nb;
                row_sum_next    = row_sum_reg + SUM_W'(nb - buf_rd);
                state_next      = last_reg ? S_ROW_CHK : S_IDLE;
            end
            S_ROW_CHK:
            begin
                k_next = '0;
                if (row_sum_reg == '0)
                begin
                    for (int i = 0; i < NUM_GROUPS; i++)
                    begin
                        buf_next[i] = '0;
                    end
                    res_next    = '0;
                    res_st_next = ST_DROP;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_ROW_DIV;
                end
            end
            S_ROW_DIV:
            begin
                if (bayes_reg)
                begin
                    state_next = S_ROW_DIVW;
                end
                else
                begin
                    share_next = buf_rd;
                    state_next = S_ROW_MUL_LO;
                end
            end
            S_ROW_DIVW:
            begin
                if (div_stat.done)
                begin
                    share_next = quotient[CNT_W-1:0];
                    state_next = S_ROW_MUL_LO;
                end
            end
            S_ROW_MUL_LO: state_next = S_ROW_MUL_HI;
            S_ROW_MUL_HI:
            begin
                lo_next    = prod;
                state_next = S_ROW_ADD;
            end
            S_ROW_ADD:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == R_W'(NUM_GROUPS - 1))
                begin
                    for (int i = 0; i < NUM_GROUPS; i++)
                    begin
                        buf_next[i] = '0;
                    end
                    row_sum_next = '0;
                    res_next     = '0;
                    res_st_next  = ST_OK;
                    state_next   = S_EMIT;
                end
                else
                begin
                    state_next = S_ROW_DIV;
                end
            end
            S_RD_RD: state_next = S_RD_CALC;
            S_RD_CALC:
            begin
                res_st_next = ST_READ;
                neg_next    = num[DIV_W-1] ^ den[DIV_W-1];
                if (raw_reg)
                begin
                    res_next   = cnt_rd_reg;
                    state_next = S_EMIT;
                end
                else if (den == 0)
                begin
                    res_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RD_DIVW;
                end
            end
            S_RD_DIVW:
            begin
                if (div_stat.done)
                begin
                    if (!neg_reg)
                    begin
                        res_next = (quotient > CNT_MAX_W) ? CNT_MAX : quotient[CNT_W-1:0];
                    end
                    else
                    begin
                        res_next = CNT_W'(-qq);
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_user_next  = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            bayes_reg     <= 1'b1;
            raw_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            row_sum_reg   <= '0;
            pri_vld_reg   <= '0;
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                buf_reg[i]  <= '0;
                csum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            bayes_reg     <= bayes_next;
            raw_reg       <= raw_next;
            out_valid_reg <= out_valid_next;
            row_sum_reg   <= row_sum_next;
            pri_vld_reg   <= pri_vld_next;
            buf_reg       <= buf_next;
            csum_reg      <= csum_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        r_reg        <= r_next;
        val_reg      <= val_next;
        wt_reg       <= wt_next;
        last_reg     <= last_next;
        share_reg    <= share_next;
        lo_reg       <= lo_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        res_st_reg   <= res_st_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // estimate memory
    always_ff @(posedge clk)
    begin
        if (est_we)
        begin
            est_mem[cell_addr] <= val_reg;
        end
        est_rd_reg <= est_mem[cell_addr];
    end

    // prior memory
    always_ff @(posedge clk)
    begin
        if (pri_we)
        begin
            pri_mem[pri_addr] <= val_reg;
        end
        pri_rd_reg <= pri_mem[pri_addr];
    end

    // count memory, swept to zero on clear
    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            cnt_mem[clearing ? clr_reg : cnt_addr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_addr];
    end

    // place total memory, swept with the low address bits
    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            tot_mem[clearing ? clr_reg[TOT_W-1:0] : tot_addr] <= tot_wdata;
        end
        tot_rd_reg <= tot_mem[tot_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // a read word always leaves the idle state
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser == KIND_READ)) |=> !s_tready)
        else $error("read word did not start the sequencer");

    // divider finishes only while a wait state expects it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ((state_reg == S_ROW_DIVW) || (state_reg == S_RD_DIVW)))
        else $error("divider result with no consumer");

    // a row with a nonzero sum is never dropped
    a_row_kept: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ROW_CHK) && (row_sum_reg != '0)) |=> (state_reg == S_ROW_DIV))
        else $error("nonzero row was dropped");

endmodule

// ===== tb/testbench.sv =====
// testbench of the dirichlet posterior accumulator: stimulus, prediction and checking
`timescale 1ns / 100ps

module testbench;
    import edpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 2000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    em_dirichlet_posterior_accumulator dut (.*);

    // predicted state
    logic [31:0] pr_prior [PRIS];
    logic [39:0] pr_colsum [NUM_GROUPS];
    logic [31:0] pr_est [CELLS];
    logic [47:0] pr_count [CELLS];
    logic [47:0] pr_total [TOTS];
    logic [47:0] pr_rowbuf [NUM_GROUPS];
    logic [55:0] pr_rowsum;
    logic        pr_bayes;
    logic        pr_sumonly;

    // expected results: status in bits 49:48, value below
    logic [49:0] expected_results [$];
    int          failures;
    int          idle_cycles;
    bit          quiet_m;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // q16 product saturated to 48 bits
    function automatic logic [47:0] mul_q16(logic [47:0] a, logic [31:0] b);
        logic [95:0] p;
        p = 96'(a) * 96'(b);
        p = p >> 16;
        if (p > 96'(BUF_MAX)) return BUF_MAX;
        return p[47:0];
    endfunction

    function automatic logic [47:0] add_cnt(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = 49'(a) + 49'(b);
        return (s > 49'(CNT_MAX)) ? CNT_MAX : s[47:0];
    endfunction

    function automatic int cell_idx(int x, int y, int r);
        return (x * NUM_OUTCOMES + y) * NUM_GROUPS + r;
    endfunction

    function automatic logic [47:0] posterior_of(int x, int y, int r);
        longint num, den;
        logic [79:0] un, ud, q;
        bit neg;
        int c;
        c = cell_idx(x, y, r);
        if (pr_sumonly) return pr_count[c];
        num = longint'(pr_prior[y * NUM_GROUPS + r]) - 65536 + longint'(pr_count[c]);
        den = longint'(pr_colsum[r]) - longint'(NUM_OUTCOMES) * 65536
            + longint'(pr_total[x * NUM_GROUPS + r]);
        if (den == 0) return '0;
        neg = (num < 0) != (den < 0);
        un = 80'(num < 0 ? -num : num);
        ud = 80'(den < 0 ? -den : den);
        q = (un << 16) / ud;
        if (!neg) return (q > 80'(CNT_MAX)) ? CNT_MAX : q[47:0];
        if (q > 80'(CNT_MAX) + 1) q = 80'(CNT_MAX) + 1;
        return 48'(-q);
    endfunction

    // apply one accepted word to the predicted state
    task automatic predict_word(logic [2:0] kind, int x, int y, int r,
                                logic [31:0] val, logic [31:0] wt, bit last);
        logic [47:0] term, nb, share, add;
        logic [79:0] wide;
        int c;
        case (kind)
            KIND_CLEAR:
            begin
                foreach (pr_count[i]) pr_count[i] = '0;
                foreach (pr_total[i]) pr_total[i] = '0;
                foreach (pr_rowbuf[i]) pr_rowbuf[i] = '0;
                pr_rowsum = '0;
            end
            KIND_PRIOR:
            begin
                pr_colsum[r] = pr_colsum[r] - pr_prior[y * NUM_GROUPS + r] + val;
                pr_prior[y * NUM_GROUPS + r] = val;
            end
            KIND_EST: pr_est[cell_idx(x, y, r)] = val;
            KIND_OBS:
            begin
                term = pr_bayes ? mul_q16(pr_est[cell_idx(x, y, r)], val) : 48'(val);
                nb = (49'(pr_rowbuf[r]) + 49'(term) > 49'(BUF_MAX)) ? BUF_MAX
                    : pr_rowbuf[r] + term;
                pr_rowsum = pr_rowsum + (nb - pr_rowbuf[r]);
                pr_rowbuf[r] = nb;
                if (last)
                begin
                    if (pr_rowsum == 0)
                        expected_results.push_back({ST_DROP, 48'd0});
                    else
                    begin
                        for (int k = 0; k < NUM_GROUPS; k++)
                        begin
                            share = pr_rowbuf[k];
                            if (pr_bayes)
                            begin
                                wide = (80'(share) << 16) / 80'(pr_rowsum);
                                share = wide[47:0];
                            end
                            add = mul_q16(share, wt);
                            c = cell_idx(x, y, k);
                            pr_count[c] = add_cnt(pr_count[c], add);
                            pr_total[x * NUM_GROUPS + k] = add_cnt(pr_total[x * NUM_GROUPS + k], add);
                        end
                        expected_results.push_back({ST_OK, 48'd0});
                    end
                    foreach (pr_rowbuf[i]) pr_rowbuf[i] = '0;
                    pr_rowsum = '0;
                end
            end
            KIND_READ: expected_results.push_back({ST_READ, posterior_of(x, y, r)});
            default: ;
        endcase
    endtask

    // send one word after a random gap; valid stays high into a word that follows at once
    task automatic send_word(logic [2:0] kind, int x, int y, int r,
                             logic [31:0] val, logic [31:0] wt, bit last, bit nogap = 0);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {2'b00, wt, val, 3'(r), 3'(y), 8'(x)};
        do @(posedge clk); while (!s_tready);
        predict_word(kind, x, y, r, val, wt, last);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == 0) pr_bayes = data[0];
        else pr_sumonly = data[0];
    endtask

    // a full row over all groups with random values
    task automatic send_row(int x, int y, logic [31:0] wt, int scale);
        for (int r = 0; r < NUM_GROUPS; r++)
            send_word(KIND_OBS, x, y, r, $urandom_range(0, scale), wt, r == NUM_GROUPS - 1);
    endtask

    task automatic test_tables();
        // priors of at least one so posteriors stay meaningful; a few extreme values
        for (int y = 0; y < NUM_OUTCOMES; y++)
            for (int r = 0; r < NUM_GROUPS; r++)
                send_word(KIND_PRIOR, 0, y, r, 32'h0001_0000 + $urandom_range(0, 32'h0004_0000),
                          $urandom, 1'b0, 1'b1);
        send_word(KIND_PRIOR, 0, 7, 7, 32'hFFFF_FFFF, 0, 1'b0);
        send_word(KIND_PRIOR, 0, 0, 0, 32'h0, 0, 1'b0);
        // estimates for places 0 to 7 and 255, the places that observations use
        for (int p = 0; p < 9; p++)
            for (int c = 0; c < NUM_OUTCOMES * NUM_GROUPS; c++)
                send_word(KIND_EST, (p == 8) ? 255 : p, c / 8, c % 8,
                          ((p * 64 + c) % 97 == 0) ? 32'hFFFF_FFFF
                                                   : $urandom_range(0, 32'h0001_0000),
                          $urandom, 1'b0, 1'b1);
    endtask

    task automatic test_directed();
        // zero row, extreme weights, extreme places, reads, unused kinds
        send_word(KIND_OBS, 3, 2, 5, 32'd0, 32'h0001_0000, 1'b1);
        send_row(255, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_row(0, 0, 32'h0, 32'h0001_0000);
        send_word(KIND_OBS, 7, 3, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(KIND_OBS, 7, 3, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(3'd5, 1, 1, 1, $urandom, $urandom, 1'b1);
        send_word(3'd6, 2, 2, 2, $urandom, $urandom, 1'b0);
        send_word(3'd7, 3, 3, 3, $urandom, $urandom, 1'b1);
        send_word(KIND_READ, 255, 7, 7, $urandom, $urandom, 1'b0);
        send_word(KIND_READ, 0, 0, 0, $urandom, $urandom, 1'b1);
        send_word(KIND_READ, 7, 3, 1, 0, 0, 1'b0);
        send_word(KIND_READ, 100, 4, 4, 0, 0, 1'b0);
    endtask

    // random phase: mostly well-formed rows on few places, with reads and noise
    task automatic test_random(int n);
        int k, x, y, len;
        k = 0;
        while (k < n)
        begin
            x = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 7);
            y = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_word(KIND_OBS, x % 8, y, $urandom_range(0, 7),
                                  $urandom_range(0, 1) ? $urandom_range(0, 32'h0001_0000)
                                                       : $urandom,
                                  $urandom_range(0, 1) ? 32'h0001_0000 : $urandom,
                                  i == len - 1);
                    k += len;
                end
                4, 5, 6:
                begin
                    send_word(KIND_READ, x, y, $urandom_range(0, 7), $urandom, $urandom,
                              $urandom_range(0, 1));
                    k++;
                end
                7:
                begin
                    send_word(KIND_EST, x % 8, y, $urandom_range(0, 7), $urandom, $urandom,
                              $urandom_range(0, 1));
                    k++;
                end
                8:
                begin
                    send_word(KIND_PRIOR, x, y, $urandom_range(0, 7),
                              32'h0001_0000 + $urandom_range(0, 32'h0008_0000), $urandom, 1'b0);
                    k++;
                end
                default:
                begin
                    send_word(3'($urandom_range(5, 7)), x, y, $urandom_range(0, 7),
                              $urandom, $urandom, $urandom_range(0, 1));
                    send_word(KIND_OBS, x % 8, y, $urandom_range(0, 7), 32'd0, $urandom, 1'b1);
                    k += 1;
                end
            endcase
        end
    endtask

    task automatic test_clear();
        send_word(KIND_CLEAR, $urandom_range(0, 255), 0, 0, $urandom, $urandom, 1'b1);
        send_word(KIND_READ, 5, 5, 5, 0, 0, 1'b0);
        send_row(5, 5, 32'h0001_0000, 32'h0001_0000);
        send_word(KIND_READ, 5, 5, 5, 0, 0, 1'b0);
    endtask

    // result checker with random stalls
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value %h status %0d", $time, m_tdata, m_tuser);
                failures++;
            end
            else
            begin
                if (m_tdata !== expected_results[0][47:0])
                begin
                    $display("%0t: value expected %h actual %h", $time,
                             expected_results[0][47:0], m_tdata);
                    failures++;
                end
                if (m_tuser !== expected_results[0][49:48])
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             expected_results[0][49:48], m_tuser);
                    failures++;
                end
                void'(expected_results.pop_front());
            end
        end
        if (quiet_m) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 15) < 8);
    end

    // stall-free stretches on the result side
    always
    begin
        repeat ($urandom_range(200, 2000)) @(posedge clk);
        quiet_m = ~quiet_m;
    end

    // watchdog on cycles with no accepted word and no taken result
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        failures = 0;
        idle_cycles = 0;
        quiet_m = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        foreach (pr_prior[i]) pr_prior[i] = '0;
        foreach (pr_colsum[i]) pr_colsum[i] = '0;
        foreach (pr_est[i]) pr_est[i] = '0;
        foreach (pr_count[i]) pr_count[i] = '0;
        foreach (pr_total[i]) pr_total[i] = '0;
        foreach (pr_rowbuf[i]) pr_rowbuf[i] = '0;
        pr_rowsum = '0;
        pr_bayes = 1'b1;
        pr_sumonly = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tables();
        test_directed();
        wait_idle();
        write_reg(1, 32'h1);
        test_directed();
        test_random(150);
        wait_idle();
        write_reg(0, 32'h0);
        write_reg(1, 32'h0);
        test_directed();
        test_random(150);
        wait_idle();
        write_reg(1, 32'hFFFF_FFFF);
        test_random(150);
        wait_idle();
        write_reg(0, 32'hFFFF_FFFF);
        write_reg(1, 32'hFFFF_FFFE);
        test_clear();
        test_random(150);
        wait_idle();

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
